>>> design/assert_macros.svh
// assertion macros shared by the scorer modules
// expects clock aclk and active-low reset aresetn in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define FSRR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition that must hold in the cycle after a trigger
`define FSRR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) ante |=> cons) \
        else $error(msg);

`endif

>>> design/fsrr_pkg.sv
// shared types and constants of the forward selection reduction scorer
// no dependencies
package fsrr_pkg;

    localparam int DEF_MAX_COLUMNS  = 32;
    localparam int DEF_FACTOR_DEPTH = 512;

    localparam int OPC_W       = 3;
    localparam int IDX_W       = 10;
    localparam int VAL_W       = 32;
    localparam int RANGE_W     = 6;
    localparam int ROW_START_W = 10;
    localparam int COLUMN_W    = 5;
    localparam int RED_W       = 48;
    localparam int FAULT_W     = 4;

    localparam logic [RANGE_W-1:0] COL_COUNT_RESET = 6'd32;

    // request opcodes
    localparam logic [OPC_W-1:0] OP_DIAG      = 3'd0;
    localparam logic [OPC_W-1:0] OP_RHS       = 3'd1;
    localparam logic [OPC_W-1:0] OP_TOL       = 3'd2;
    localparam logic [OPC_W-1:0] OP_FACTOR    = 3'd3;
    localparam logic [OPC_W-1:0] OP_ROW_START = 3'd4;
    localparam logic [OPC_W-1:0] OP_COMPUTE   = 3'd5;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_DIAG_RHS = 3'd0,
        MUL_R_R      = 3'd1,
        MUL_DIAG_R2  = 3'd2,
        MUL_DY_R     = 3'd3,
        MUL_TOL_TOL  = 3'd4
    } mul_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     accept;
        logic     col_init;
        logic     set_sxy;
        logic     fread;
        logic     rstep;
        logic     acc_xx;
        logic     acc_xy;
        logic     cmp;
        logic     sq_step;
        logic     div_step;
        logic     emit;
        logic     emit_fault;
        logic     use_row;
        mul_sel_t mul_sel;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_compute;
        logic range_bad;
        logic row_more;
        logic row_next_more;
        logic pass;
        logic sq_last;
        logic div_last;
        logic out_free;
        logic col_last;
    } status_t;

endpackage

>>> design/forward_selection_rss_reduction.sv
// Forward selection scorer: load requests (opcodes 0 to 4) fill the diagonal,
// right-hand side, tolerance, row start and packed factor tables and are taken
// without leaving the idle state; opcodes 6 and 7 are dropped. A compute
// request scores columns first..end-1 one after another, one result per
// column, or a single result for a faulty or empty range. For every earlier
// row of the range a column runs FREAD, RSTEP, R2, T1 and T2 (one shared 32x32
// multiplier does four products per row, fed from the factor memory's
// registered read); each column also passes the setup, threshold test and
// result hand-off states COLDY, COLSY, TOL, CMP and EMIT, and one that passes
// the tolerance test runs the bit-serial square and restoring divide in
// between, on SW-bit values with SW = 32 + clog2(MAX_COLUMNS+1). A result
// waits in EMIT until the output register is free. One request is worked at
// a time; the next is taken once the last result sits in the output register.
// Files: fsrr_pkg, fsrr_ctrl, fsrr_dpath, assert_macros.svh.

module forward_selection_rss_reduction #(
    parameter int MAX_COLUMNS  = fsrr_pkg::DEF_MAX_COLUMNS,
    parameter int FACTOR_DEPTH = fsrr_pkg::DEF_FACTOR_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write_en,
    input  logic [fsrr_pkg::RANGE_W-1:0]        cfg_write_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fsrr_pkg::OPC_W-1:0]          s_opcode,
    input  logic [fsrr_pkg::IDX_W-1:0]          s_table_index,
    input  logic signed [fsrr_pkg::VAL_W-1:0]   s_load_value,
    input  logic [fsrr_pkg::RANGE_W-1:0]        s_first_column,
    input  logic [fsrr_pkg::RANGE_W-1:0]        s_end_column,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fsrr_pkg::COLUMN_W-1:0]       m_column,
    output logic [fsrr_pkg::RED_W-1:0]          m_reduction,
    output logic [fsrr_pkg::COLUMN_W-1:0]       m_best_column,
    output logic [fsrr_pkg::RED_W-1:0]          m_best_reduction,
    output logic [fsrr_pkg::FAULT_W-1:0]        m_fault_flags,
    output logic                                m_last_of_run
);

    fsrr_pkg::cmd_t    cmd;
    fsrr_pkg::status_t st;

    // sequencer
    fsrr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // tables, arithmetic and output register
    fsrr_dpath #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .FACTOR_DEPTH (FACTOR_DEPTH)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .s_opcode         (s_opcode),
        .s_table_index    (s_table_index),
        .s_load_value     (s_load_value),
        .s_first_column   (s_first_column),
        .s_end_column     (s_end_column),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_column         (m_column),
        .m_reduction      (m_reduction),
        .m_best_column    (m_best_column),
        .m_best_reduction (m_best_reduction),
        .m_fault_flags    (m_fault_flags),
        .m_last_of_run    (m_last_of_run)
    );

endmodule

>>> design/fsrr_ctrl.sv
// sequencing state machine of the reduction scorer
// depends on fsrr_pkg and assert_macros.svh
`include "assert_macros.svh"

module fsrr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fsrr_pkg::status_t st,
    output fsrr_pkg::cmd_t   cmd
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_FAULT = 14'b00000000000010,
        S_COLDY = 14'b00000000000100,
        S_COLSY = 14'b00000000001000,
        S_FREAD = 14'b00000000010000,
        S_RSTEP = 14'b00000000100000,
        S_R2    = 14'b00000001000000,
        S_T1    = 14'b00000010000000,
        S_T2    = 14'b00000100000000,
        S_TOL   = 14'b00001000000000,
        S_CMP   = 14'b00010000000000,
        S_SQ    = 14'b00100000000000,
        S_DIV   = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = fsrr_pkg::MUL_DIAG_RHS;
        s_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (st.is_compute) begin
                        state_next = st.range_bad ? S_FAULT : S_COLDY;
                    end
                end
            end
            S_FAULT: begin
                if (st.out_free) begin
                    cmd.emit_fault = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_COLDY: begin
                cmd.col_init = 1'b1;
                cmd.mul_sel  = fsrr_pkg::MUL_DIAG_RHS;
                state_next   = S_COLSY;
            end
            S_COLSY: begin
                cmd.set_sxy = 1'b1;
                state_next  = st.row_more ? S_FREAD : S_TOL;
            end
            S_FREAD: begin
                cmd.fread   = 1'b1;
                cmd.use_row = 1'b1;
                cmd.mul_sel = fsrr_pkg::MUL_DIAG_RHS;
                state_next  = S_RSTEP;
            end
            S_RSTEP: begin
                cmd.rstep   = 1'b1;
                cmd.mul_sel = fsrr_pkg::MUL_R_R;
                state_next  = S_R2;
            end
            S_R2: begin
                cmd.use_row = 1'b1;
                cmd.mul_sel = fsrr_pkg::MUL_DIAG_R2;
                state_next  = S_T1;
            end
            S_T1: begin
                cmd.acc_xx  = 1'b1;
                cmd.mul_sel = fsrr_pkg::MUL_DY_R;
                state_next  = S_T2;
            end
            S_T2: begin
                cmd.acc_xy = 1'b1;
                state_next = st.row_next_more ? S_FREAD : S_TOL;
            end
            S_TOL: begin
                cmd.mul_sel = fsrr_pkg::MUL_TOL_TOL;
                state_next  = S_CMP;
            end
            S_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = st.pass ? S_SQ : S_EMIT;
            end
            S_SQ: begin
                cmd.sq_step = 1'b1;
                if (st.sq_last) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = st.col_last ? S_IDLE : S_COLDY;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // checks
    `FSRR_ASSERT_NEXT(a_cmp_fail_emits, (state_reg == S_CMP && !st.pass),
        (state_reg == S_EMIT), "failed threshold must go straight to emit")
    `FSRR_ASSERT_NEXT(a_last_col_idle, (state_reg == S_EMIT && st.out_free && st.col_last),
        (state_reg == S_IDLE), "run did not end after last column")
    `FSRR_ASSERT(a_emit_has_room, ((cmd.emit || cmd.emit_fault) |-> st.out_free),
        "result written while output register is full")

endmodule

>>> design/fsrr_dpath.sv
// tables, factor memory, shared multiplier, square and divide unit, output register
// depends on fsrr_pkg and assert_macros.svh
`include "assert_macros.svh"

module fsrr_dpath #(
    parameter int MAX_COLUMNS  = fsrr_pkg::DEF_MAX_COLUMNS,
    parameter int FACTOR_DEPTH = fsrr_pkg::DEF_FACTOR_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fsrr_pkg::cmd_t                      cmd,
    output fsrr_pkg::status_t                   st,
    input  logic                                cfg_write_en,
    input  logic [fsrr_pkg::RANGE_W-1:0]        cfg_write_data,
    input  logic [fsrr_pkg::OPC_W-1:0]          s_opcode,
    input  logic [fsrr_pkg::IDX_W-1:0]          s_table_index,
    input  logic signed [fsrr_pkg::VAL_W-1:0]   s_load_value,
    input  logic [fsrr_pkg::RANGE_W-1:0]        s_first_column,
    input  logic [fsrr_pkg::RANGE_W-1:0]        s_end_column,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fsrr_pkg::COLUMN_W-1:0]       m_column,
    output logic [fsrr_pkg::RED_W-1:0]          m_reduction,
    output logic [fsrr_pkg::COLUMN_W-1:0]       m_best_column,
    output logic [fsrr_pkg::RED_W-1:0]          m_best_reduction,
    output logic [fsrr_pkg::FAULT_W-1:0]        m_fault_flags,
    output logic                                m_last_of_run
);

    localparam int CIW  = $clog2(MAX_COLUMNS);
    localparam int JW   = $clog2(MAX_COLUMNS + 1);
    localparam int AW   = (FACTOR_DEPTH > 1) ? $clog2(FACTOR_DEPTH) : 1;
    localparam int PW   = $clog2(1024 + MAX_COLUMNS * MAX_COLUMNS) + 1;
    localparam int SW   = 32 + $clog2(MAX_COLUMNS + 1);
    localparam int MW   = $clog2(SW);
    localparam int CNTW = $clog2(2 * SW);
    localparam int RW   = fsrr_pkg::RED_W;
    localparam int VW   = fsrr_pkg::VAL_W;

    localparam logic [fsrr_pkg::IDX_W-1:0] TAB_DEPTH = fsrr_pkg::IDX_W'(MAX_COLUMNS);

    // floor of a q16.16 product, clamped to 32 bits
    function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
        logic signed [47:0] f;
        f = 48'(p >>> 16);
        if (f > 48'sh0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (f < -48'sh0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return 32'(f);
    endfunction

    logic [fsrr_pkg::RANGE_W-1:0] cc_reg;

    logic signed [VW-1:0]                 diag_tab [MAX_COLUMNS];
    logic signed [VW-1:0]                 rhs_tab  [MAX_COLUMNS];
    logic signed [VW-1:0]                 tol_tab  [MAX_COLUMNS];
    logic [fsrr_pkg::ROW_START_W-1:0]     rs_tab   [MAX_COLUMNS];
    logic signed [VW-1:0]                 factor_mem [FACTOR_DEPTH];

    logic signed [VW-1:0] fq_reg;
    logic                 pos_ok_reg;
    logic [JW-1:0]        first_reg, last_reg, j_reg, i_reg;
    logic [PW-1:0]        base_reg;
    logic [fsrr_pkg::FAULT_W-1:0] flt_reg;
    logic signed [63:0]   p_reg;
    logic signed [VW-1:0] dy_reg, r_reg;
    logic signed [SW-1:0] sxx_reg, sxy_reg;
    logic [SW-1:0]        mag_reg, rem_reg;
    logic [2*SW-1:0]      acc_reg, num_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [RW-1:0]        red_reg, max_val_reg;
    logic [fsrr_pkg::COLUMN_W-1:0] max_idx_reg;

    logic                          m_valid_reg, m_last_reg;
    logic [fsrr_pkg::COLUMN_W-1:0] m_col_reg, m_bcol_reg;
    logic [RW-1:0]                 m_red_reg, m_bred_reg;
    logic [fsrr_pkg::FAULT_W-1:0]  m_flt_reg;

    // column count clamp and range checks
    logic [JW-1:0]                cols;
    logic [6:0]                   cols7, f7, e7;
    logic [fsrr_pkg::FAULT_W-1:0] flt;

    assign cols  = (7'(cc_reg) > 7'(MAX_COLUMNS)) ? JW'(MAX_COLUMNS) : JW'(cc_reg);
    assign cols7 = 7'(cols);
    assign f7    = 7'(s_first_column);
    assign e7    = 7'(s_end_column);
    assign flt   = {e7 > cols7, f7 == 7'd0, e7 < f7, f7 > cols7};

    // table reads
    logic [JW-1:0]        tab_addr;
    logic signed [VW-1:0] diag_rd, rhs_rd, tol_rd, rsel, qp;
    logic [PW-1:0]        pos;

    assign tab_addr = cmd.use_row ? i_reg : j_reg;
    assign diag_rd  = diag_tab[tab_addr[CIW-1:0]];
    assign rhs_rd   = rhs_tab[tab_addr[CIW-1:0]];
    assign tol_rd   = tol_tab[j_reg[CIW-1:0]];
    assign rsel     = pos_ok_reg ? fq_reg : '0;
    assign qp       = qsat(p_reg);
    assign pos      = base_reg + PW'(j_reg) - PW'(i_reg) - PW'(1);

    // shared multiplier operands
    logic signed [VW-1:0] mul_a, mul_b;
    logic signed [63:0]   mul_full;

    always_comb begin
        unique case (cmd.mul_sel)
            fsrr_pkg::MUL_DIAG_RHS: begin
                mul_a = diag_rd;
                mul_b = rhs_rd;
            end
            fsrr_pkg::MUL_R_R: begin
                mul_a = rsel;
                mul_b = rsel;
            end
            fsrr_pkg::MUL_DIAG_R2: begin
                mul_a = diag_rd;
                mul_b = qp;
            end
            fsrr_pkg::MUL_DY_R: begin
                mul_a = dy_reg;
                mul_b = r_reg;
            end
            fsrr_pkg::MUL_TOL_TOL: begin
                mul_a = tol_rd;
                mul_b = tol_rd;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // threshold, square and divide step logic
    logic signed [63:0] sxx_sh;
    logic [SW-1:0]      sxy_neg;
    logic [MW-1:0]      sq_bit;
    logic [2*SW-1:0]    acc_next, num_next;
    logic [SW:0]        div_sh;
    logic               div_ge;
    logic               col_last, gt;

    assign sxx_sh   = 64'(sxx_reg) <<< 16;
    assign sxy_neg  = SW'(-sxy_reg);
    assign sq_bit   = MW'(SW - 1) - cnt_reg[MW-1:0];
    assign acc_next = {acc_reg[2*SW-2:0], 1'b0} + (mag_reg[sq_bit] ? (2*SW)'(mag_reg) : '0);
    assign div_sh   = {rem_reg, num_reg[2*SW-1]};
    assign div_ge   = div_sh >= (SW+1)'(sxx_reg);
    assign num_next = {num_reg[2*SW-2:0], div_ge};
    assign col_last = (j_reg + JW'(1)) == last_reg;
    assign gt       = red_reg > max_val_reg;

    // status to controller
    always_comb begin
        st               = '0;
        st.is_compute    = s_opcode == fsrr_pkg::OP_COMPUTE;
        st.range_bad     = (flt != '0) || (s_first_column == s_end_column);
        st.row_more      = i_reg < j_reg;
        st.row_next_more = (i_reg + JW'(1)) < j_reg;
        st.pass          = sxx_sh > p_reg;
        st.sq_last       = cnt_reg == CNTW'(SW - 1);
        st.div_last      = cnt_reg == CNTW'(2 * SW - 1);
        st.out_free      = !m_valid_reg || m_ready;
        st.col_last      = col_last;
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg <= fsrr_pkg::COL_COUNT_RESET;
        end else if (cfg_write_en) begin
            cc_reg <= cfg_write_data;
        end
    end

    // small tables, written by load requests
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_table_index < TAB_DEPTH) begin
            unique case (s_opcode)
                fsrr_pkg::OP_DIAG:      diag_tab[s_table_index[CIW-1:0]] <= s_load_value;
                fsrr_pkg::OP_RHS:       rhs_tab[s_table_index[CIW-1:0]]  <= s_load_value;
                fsrr_pkg::OP_TOL:       tol_tab[s_table_index[CIW-1:0]]  <= s_load_value;
                fsrr_pkg::OP_ROW_START: begin
                    rs_tab[s_table_index[CIW-1:0]] <= s_load_value[fsrr_pkg::ROW_START_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // packed factor memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_opcode == fsrr_pkg::OP_FACTOR
            && 32'(s_table_index) < 32'(FACTOR_DEPTH)) begin
            factor_mem[s_table_index[AW-1:0]] <= s_load_value;
        end
        if (cmd.fread) begin
            fq_reg     <= factor_mem[pos[AW-1:0]];
            pos_ok_reg <= 32'(pos) < 32'(FACTOR_DEPTH);
        end
    end

    // multiplier output register
    always_ff @(posedge aclk) begin
        p_reg <= mul_full;
    end

    // column walk and accumulation
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_opcode == fsrr_pkg::OP_COMPUTE) begin
            first_reg <= JW'(s_first_column);
            last_reg  <= JW'(s_end_column);
            j_reg     <= JW'(s_first_column);
            flt_reg   <= flt;
        end
        if (cmd.col_init) begin
            i_reg    <= first_reg;
            base_reg <= PW'(rs_tab[first_reg[CIW-1:0]]);
            sxx_reg  <= SW'(diag_rd);
        end
        if (cmd.set_sxy) begin
            sxy_reg <= SW'(qp);
        end
        if (cmd.rstep) begin
            dy_reg <= qp;
            r_reg  <= rsel;
        end
        if (cmd.acc_xx) begin
            sxx_reg <= sxx_reg + SW'(qp);
        end
        if (cmd.acc_xy) begin
            sxy_reg  <= sxy_reg + SW'(qp);
            i_reg    <= i_reg + JW'(1);
            base_reg <= base_reg + PW'(cols) - PW'(i_reg) - PW'(1);
        end
        if (cmd.emit) begin
            j_reg <= j_reg + JW'(1);
        end
    end

    // square by shift and add over the magnitude bits, then restoring divide
    always_ff @(posedge aclk) begin
        if (cmd.cmp) begin
            red_reg <= '0;
            mag_reg <= sxy_reg[SW-1] ? sxy_neg : SW'(sxy_reg);
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.sq_step) begin
            acc_reg <= acc_next;
            if (st.sq_last) begin
                num_reg <= acc_next;
                rem_reg <= '0;
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
        end
        if (cmd.div_step) begin
            rem_reg <= div_ge ? SW'(div_sh - (SW+1)'(sxx_reg)) : SW'(div_sh);
            num_reg <= num_next;
            cnt_reg <= cnt_reg + CNTW'(1);
            if (st.div_last) begin
                red_reg <= (|num_next[2*SW-1:RW]) ? '1 : num_next[RW-1:0];
            end
        end
    end

    // running maximum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_val_reg <= '0;
            max_idx_reg <= '0;
        end else if (cmd.accept && s_opcode == fsrr_pkg::OP_COMPUTE) begin
            max_val_reg <= '0;
            max_idx_reg <= '0;
        end else if (cmd.emit && gt) begin
            max_val_reg <= red_reg;
            max_idx_reg <= fsrr_pkg::COLUMN_W'(j_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.emit_fault) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_col_reg  <= fsrr_pkg::COLUMN_W'(j_reg);
            m_red_reg  <= red_reg;
            m_bcol_reg <= gt ? fsrr_pkg::COLUMN_W'(j_reg) : max_idx_reg;
            m_bred_reg <= gt ? red_reg : max_val_reg;
            m_flt_reg  <= '0;
            m_last_reg <= col_last;
        end else if (cmd.emit_fault) begin
            m_col_reg  <= '0;
            m_red_reg  <= '0;
            m_bcol_reg <= '0;
            m_bred_reg <= '0;
            m_flt_reg  <= flt_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_column         = m_col_reg;
    assign m_reduction      = m_red_reg;
    assign m_best_column    = m_bcol_reg;
    assign m_best_reduction = m_bred_reg;
    assign m_fault_flags    = m_flt_reg;
    assign m_last_of_run    = m_last_reg;

    // checks
    `FSRR_ASSERT_NEXT(a_best_dominates, (cmd.emit), (m_best_reduction >= m_reduction),
        "best reduction below current reduction")
    `FSRR_ASSERT_NEXT(a_fault_result, (cmd.emit_fault),
        (m_reduction == '0 && m_last_of_run), "fault result not cleared or not last")
    `FSRR_ASSERT(a_den_positive, (cmd.div_step |-> (!sxx_reg[SW-1] && sxx_reg != '0)),
        "divide started with a non-positive denominator")

endmodule
